@@ hdl/gha_pkg.sv @@
// shared constants and beat types for the generational handle allocator
`timescale 1ns / 1ps

package gha_pkg;

    localparam int NUM_SLOTS    = 32;
    localparam int VERSION_BITS = 16;
    localparam int DIRTY_DEPTH  = 64;

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int DADDR_W  = $clog2(DIRTY_DEPTH);
    localparam int DCNT_W   = $clog2(DIRTY_DEPTH + 1);
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;

    localparam logic [OPCODE_W-1:0] OP_ALLOC     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MARK      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_POP_DIRTY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL           = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_DIRTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIRTY_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIRTY_OVERFLOW = 3'd5;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [SLOT_W-1:0]       slot_index;
        logic [VERSION_BITS-1:0] handle_version;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       out_slot;
        logic [VERSION_BITS-1:0] out_version;
    } t_out_beat;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic [VERSION_BITS-1:0] version;
    } t_handle;

    typedef struct packed {
        logic    push;
        logic    pop;
        t_handle entry;
    } t_dirty_cmd;

    typedef struct packed {
        logic    empty;
        logic    full;
        t_handle top;
    } t_dirty_stat;

endpackage

@@ hdl/generational_handle_allocator_top.sv @@
// top level: request and result registers around the allocator core
//
// request channel: i_in_valid, i_in_data, o_in_stall; a beat is taken at a
// rising edge with i_in_valid high and o_in_stall low
// result channel: o_out_valid, o_out_data, i_out_stall; one result beat per
// request beat, in request order
// opcodes: allocate, free, mark dirty, lookup, pop dirty
// path: a request taken into the request register is decoded there and its result is loaded into the result register
// throughput: one beat per cycle while the result is not stalled, set by the
// single decode and update pass between the request and result registers
// the dirty stack memory keeps its top entry in a registered read port
// reset (i_rst_n low, synchronous): all slots dead and clean, no slots used,
// both stacks empty, both registers empty
// a stalled result holds o_out_data; the request register then holds too,
// and o_in_stall rises once it carries a waiting beat
`timescale 1ns / 1ps

module generational_handle_allocator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  gha_pkg::t_in_beat  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output gha_pkg::t_out_beat o_out_data,
    input  logic               i_out_stall
);

    logic               r_in_v;
    gha_pkg::t_in_beat  r_in;
    logic               r_out_v;
    gha_pkg::t_out_beat r_out;
    logic               n_in_v;
    logic               n_out_v;
    logic               exec;
    logic               in_acc;
    gha_pkg::t_out_beat result;

    assign exec       = r_in_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_in_v && !exec;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign n_in_v     = in_acc || (r_in_v && !exec);
    assign n_out_v    = exec || (r_out_v && i_out_stall);

    gha_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (exec),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (exec) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stall without a stalled result");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !(o_out_valid && i_out_stall)) |=> o_out_valid)
        else $error("executed beat produced no result");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_v)
        else $error("accepted beat lost from request register");
`endif

endmodule

@@ hdl/gha_dirty_stack.sv @@
// dirty handle stack: memory with a registered top-of-stack read
`timescale 1ns / 1ps

module gha_dirty_stack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gha_pkg::t_dirty_cmd  i_cmd,
    output gha_pkg::t_dirty_stat o_stat
);

    gha_pkg::t_handle r_mem [gha_pkg::DIRTY_DEPTH];
    gha_pkg::t_handle r_rd;
    logic [gha_pkg::DCNT_W-1:0]  r_top;
    logic [gha_pkg::DCNT_W-1:0]  n_top;
    logic [gha_pkg::DADDR_W-1:0] wr_addr;
    logic [gha_pkg::DADDR_W-1:0] rd_addr;

    assign n_top   = r_top + gha_pkg::DCNT_W'(i_cmd.push) - gha_pkg::DCNT_W'(i_cmd.pop);
    assign wr_addr = r_top[gha_pkg::DADDR_W-1:0];
    assign rd_addr = gha_pkg::DADDR_W'(n_top - gha_pkg::DCNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else begin
            r_top <= n_top;
        end
    end

    // read at the next top so r_rd always holds the current top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= i_cmd.entry;
        end
        if (i_cmd.push && (wr_addr == rd_addr)) begin
            r_rd <= i_cmd.entry;
        end else begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_stat.empty = (r_top == '0);
    assign o_stat.full  = (r_top == gha_pkg::DCNT_W'(gha_pkg::DIRTY_DEPTH));
    assign o_stat.top   = r_rd;

endmodule

@@ hdl/gha_core.sv @@
// slot table, free stack and operation decode for one beat
`timescale 1ns / 1ps

module gha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  gha_pkg::t_in_beat  i_item,
    output gha_pkg::t_out_beat o_result
);

    localparam int SW = gha_pkg::SLOT_W;
    localparam int CW = gha_pkg::CNT_W;
    localparam int VB = gha_pkg::VERSION_BITS;

    logic [VB-1:0]                r_ver  [gha_pkg::NUM_SLOTS];
    logic [SW-1:0]                r_free [gha_pkg::NUM_SLOTS];
    logic [gha_pkg::NUM_SLOTS-1:0] r_alive;
    logic [gha_pkg::NUM_SLOTS-1:0] r_dirty;
    logic [CW-1:0]                r_used;
    logic [CW-1:0]                r_ftop;

    gha_pkg::t_dirty_cmd  dcmd;
    gha_pkg::t_dirty_stat dstat;

    logic          free_nempty;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] ver_addr;
    logic [VB-1:0] ver_rd;
    logic          hit;
    logic          alloc_en;
    logic          alloc_fresh;
    logic [SW-1:0] alloc_slot;
    logic [VB-1:0] alloc_ver;
    logic          release_en;
    logic          dirty_set;
    logic          want_push;
    logic          want_pop;

    assign free_nempty = (r_ftop != '0);
    assign free_slot   = r_free[SW'(r_ftop - CW'(1))];
    assign ver_addr    = (i_item.opcode == gha_pkg::OP_ALLOC) ? free_slot : i_item.slot_index;
    assign ver_rd      = r_ver[ver_addr];
    assign hit         = ({1'b0, i_item.slot_index} < r_used)
                      && r_alive[i_item.slot_index]
                      && (ver_rd == i_item.handle_version);

    always_comb begin
        o_result    = '0;
        alloc_en    = 1'b0;
        alloc_fresh = 1'b0;
        alloc_slot  = free_slot;
        alloc_ver   = VB'(ver_rd + VB'(1));
        release_en  = 1'b0;
        dirty_set   = 1'b0;
        want_push   = 1'b0;
        want_pop    = 1'b0;
        unique case (i_item.opcode)
            gha_pkg::OP_ALLOC: begin
                if (free_nempty) begin
                    alloc_en = 1'b1;
                end else if (r_used != CW'(gha_pkg::NUM_SLOTS)) begin
                    alloc_en    = 1'b1;
                    alloc_fresh = 1'b1;
                    alloc_slot  = SW'(r_used);
                    alloc_ver   = '0;
                end else begin
                    o_result.status = gha_pkg::ST_FULL;
                end
                if (alloc_en) begin
                    o_result.out_slot    = alloc_slot;
                    o_result.out_version = alloc_ver;
                end
            end
            gha_pkg::OP_FREE: begin
                if (!hit) begin
                    o_result.status = gha_pkg::ST_INVALID;
                end else begin
                    release_en = 1'b1;
                    dirty_set  = 1'b1;
                    want_push  = !dstat.full;
                    if (dstat.full) begin
                        o_result.status = gha_pkg::ST_DIRTY_OVERFLOW;
                    end
                    o_result.out_slot    = i_item.slot_index;
                    o_result.out_version = i_item.handle_version;
                end
            end
            gha_pkg::OP_MARK: begin
                if (!hit) begin
                    o_result.status = gha_pkg::ST_INVALID;
                end else if (r_dirty[i_item.slot_index]) begin
                    o_result.status = gha_pkg::ST_ALREADY_DIRTY;
                end else if (dstat.full) begin
                    o_result.status = gha_pkg::ST_DIRTY_OVERFLOW;
                end else begin
                    dirty_set = 1'b1;
                    want_push = 1'b1;
                end
            end
            gha_pkg::OP_LOOKUP: begin
                if (!hit) begin
                    o_result.status = gha_pkg::ST_INVALID;
                end else begin
                    o_result.out_slot    = i_item.slot_index;
                    o_result.out_version = i_item.handle_version;
                end
            end
            gha_pkg::OP_POP_DIRTY: begin
                if (dstat.empty) begin
                    o_result.status = gha_pkg::ST_DIRTY_EMPTY;
                end else begin
                    want_pop             = 1'b1;
                    o_result.out_slot    = dstat.top.slot;
                    o_result.out_version = dstat.top.version;
                end
            end
            default: begin
                o_result.status = gha_pkg::ST_INVALID;
            end
        endcase
    end

    assign dcmd.push          = i_fire && want_push;
    assign dcmd.pop           = i_fire && want_pop;
    assign dcmd.entry.slot    = i_item.slot_index;
    assign dcmd.entry.version = i_item.handle_version;

    gha_dirty_stack u_dirty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dcmd),
        .o_stat  (dstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_dirty <= '0;
            r_used  <= '0;
            r_ftop  <= '0;
        end else if (i_fire) begin
            if (alloc_en) begin
                r_alive[alloc_slot] <= 1'b1;
                r_dirty[alloc_slot] <= 1'b0;
                if (alloc_fresh) begin
                    r_used <= r_used + CW'(1);
                end else begin
                    r_ftop <= r_ftop - CW'(1);
                end
            end
            if (release_en) begin
                r_alive[i_item.slot_index] <= 1'b0;
                if (r_ftop != CW'(gha_pkg::NUM_SLOTS)) begin
                    r_ftop <= r_ftop + CW'(1);
                end
            end
            if (dirty_set) begin
                r_dirty[i_item.slot_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && alloc_en) begin
            r_ver[alloc_slot] <= alloc_ver;
        end
        if (i_fire && release_en && (r_ftop != CW'(gha_pkg::NUM_SLOTS))) begin
            r_free[SW'(r_ftop)] <= i_item.slot_index;
        end
    end

endmodule
